[design/tlvp_pkg.sv]
// Package for the TLV message parser: event and status codes, field widths
// and the result item type shared by the parser core, output buffer and top level.
// No dependencies.
package tlvp_pkg;

  localparam logic [15:0] START_WORD_RESET = 16'h4040;
  localparam int unsigned HDR_BYTES  = 6;
  localparam int unsigned PHDR_BYTES = 4;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_HEADER  = 3'd1;
  localparam logic [2:0] EV_PHDR    = 3'd2;
  localparam logic [2:0] EV_DATA    = 3'd3;
  localparam logic [2:0] EV_IGNORED = 3'd4;

  localparam logic [2:0] ST_OPEN     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_BADSTART = 3'd3;
  localparam logic [2:0] ST_BADTOTAL = 3'd4;
  localparam logic [2:0] ST_BADPARAM = 3'd5;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] msg_id;
    logic [15:0] param_id;
    logic [15:0] param_length;
    logic [7:0]  data_byte;
    logic [15:0] data_index;
    logic [2:0]  final_status;
    logic        done_res;
  } result_t;

endpackage

[design/tlvp_core.sv]
// Parser core of the TLV message parser: start word register, parse state and
// the single-pass next-state and result logic for one byte.
// Depends on tlvp_pkg.
module tlvp_core import tlvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output result_t     res
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PHDR   = 2'd1;
  localparam logic [1:0] PH_PDATA  = 2'd2;
  localparam logic [1:0] PH_IGNORE = 2'd3;

  logic [15:0] start_word;
  logic [1:0]  phase, phase_next;
  logic [15:0] message_offset, message_offset_next;
  logic [15:0] header_word, header_word_next;
  logic        start_mismatch, start_mismatch_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] current_msg_id, current_msg_id_next;
  logic [15:0] current_param_length, current_param_length_next;
  logic [15:0] current_param_id, current_param_id_next;
  logic [15:0] param_byte_count, param_byte_count_next;
  logic [2:0]  error_code, error_code_next;

  logic [15:0] pos;
  logic [15:0] hw_shift;
  logic [16:0] pos_plus1;
  logic [15:0] pstart;
  logic [15:0] rem;
  logic [15:0] pcount_inc;

  // Another parameter header follows only if at least four bytes of the
  // total length remain after next_pos.
  function automatic logic [1:0] walk_phase(input logic [15:0] total,
                                            input logic [16:0] next_pos);
    logic [17:0] need;
    need = {1'b0, next_pos} + 18'(PHDR_BYTES);
    return ({2'b00, total} >= need) ? PH_PHDR : PH_IGNORE;
  endfunction

  always_comb begin
    pos        = message_offset;
    hw_shift   = {header_word[7:0], in_byte};
    pos_plus1  = {1'b0, pos} + 17'd1;
    pstart     = pos - 16'd3;
    rem        = (total_length > pstart) ? (total_length - pstart) : 16'd0;
    pcount_inc = param_byte_count + 16'd1;

    phase_next                = phase;
    message_offset_next       = (message_offset != 16'hFFFF) ? pos_plus1[15:0]
                                                             : message_offset;
    header_word_next          = header_word;
    start_mismatch_next       = start_mismatch;
    total_length_next         = total_length;
    current_msg_id_next       = current_msg_id;
    current_param_length_next = current_param_length;
    current_param_id_next     = current_param_id;
    param_byte_count_next     = param_byte_count;
    error_code_next           = error_code;

    res = '0;
    res.event_res = EV_IGNORED;

    unique case (phase)
      PH_HEADER: begin
        header_word_next = hw_shift;
        res.event_res    = EV_NONE;
        if (pos == 16'd1) begin
          start_mismatch_next = (hw_shift != start_word);
        end else if (pos == 16'd3) begin
          total_length_next = hw_shift;
        end else if (pos >= 16'd5) begin
          current_msg_id_next = hw_shift;
          if (start_mismatch) begin
            error_code_next = ST_BADSTART;
            phase_next      = PH_IGNORE;
          end else if (total_length < 16'(HDR_BYTES)) begin
            error_code_next = ST_BADTOTAL;
            phase_next      = PH_IGNORE;
          end else begin
            res.event_res         = EV_HEADER;
            param_byte_count_next = '0;
            phase_next            = walk_phase(total_length, 17'(HDR_BYTES));
          end
        end
      end
      PH_PHDR: begin
        header_word_next      = hw_shift;
        param_byte_count_next = pcount_inc;
        res.event_res         = EV_NONE;
        if (pcount_inc == 16'd2) begin
          current_param_length_next = hw_shift;
        end else if (pcount_inc >= 16'(PHDR_BYTES)) begin
          current_param_id_next = hw_shift;
          if (current_param_length < 16'(PHDR_BYTES) || current_param_length > rem) begin
            error_code_next = ST_BADPARAM;
            phase_next      = PH_IGNORE;
          end else begin
            res.event_res = EV_PHDR;
            if (current_param_length == 16'(PHDR_BYTES)) begin
              param_byte_count_next = '0;
              phase_next            = walk_phase(total_length, pos_plus1);
            end else begin
              phase_next = PH_PDATA;
            end
          end
        end
      end
      PH_PDATA: begin
        res.event_res         = EV_DATA;
        res.data_byte         = in_byte;
        res.data_index        = param_byte_count - 16'(PHDR_BYTES);
        param_byte_count_next = pcount_inc;
        if (pcount_inc >= current_param_length) begin
          param_byte_count_next = '0;
          phase_next            = walk_phase(total_length, pos_plus1);
        end
      end
      PH_IGNORE: begin
        res.event_res = EV_IGNORED;
      end
      default: begin
        res.event_res = EV_IGNORED;
      end
    endcase

    res.msg_id       = current_msg_id_next;
    res.param_id     = current_param_id_next;
    res.param_length = current_param_length_next;
    res.done_res     = in_last;
    res.final_status = ST_OPEN;

    if (in_last) begin
      if (message_offset_next < 16'(HDR_BYTES)) begin
        res.final_status = ST_SHORT;
      end else if (error_code_next == ST_BADSTART || error_code_next == ST_BADTOTAL) begin
        res.final_status = error_code_next;
      end else if (total_length_next > message_offset_next) begin
        res.final_status = ST_BADTOTAL;
      end else if (error_code_next == ST_BADPARAM) begin
        res.final_status = ST_BADPARAM;
      end else begin
        res.final_status = ST_OK;
      end
      // The buffer is finished: the next byte opens a new message.
      phase_next                = PH_HEADER;
      message_offset_next       = '0;
      header_word_next          = '0;
      start_mismatch_next       = 1'b0;
      total_length_next         = '0;
      current_msg_id_next       = '0;
      current_param_length_next = '0;
      current_param_id_next     = '0;
      param_byte_count_next     = '0;
      error_code_next           = ST_OPEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_word           <= START_WORD_RESET;
      phase                <= PH_HEADER;
      message_offset       <= '0;
      header_word          <= '0;
      start_mismatch       <= 1'b0;
      total_length         <= '0;
      current_msg_id       <= '0;
      current_param_length <= '0;
      current_param_id     <= '0;
      param_byte_count     <= '0;
      error_code           <= ST_OPEN;
    end else begin
      if (cfg_we) begin
        start_word <= cfg_data;
      end
      if (step) begin
        phase                <= phase_next;
        message_offset       <= message_offset_next;
        header_word          <= header_word_next;
        start_mismatch       <= start_mismatch_next;
        total_length         <= total_length_next;
        current_msg_id       <= current_msg_id_next;
        current_param_length <= current_param_length_next;
        current_param_id     <= current_param_id_next;
        param_byte_count     <= param_byte_count_next;
        error_code           <= error_code_next;
      end
    end
  end

endmodule

[design/tlvp_out_buf.sv]
// Output stage of the TLV message parser: a result register with a skid
// entry, so that the core can pass on one more result while one waits to be taken.
// Depends on tlvp_pkg.
module tlvp_out_buf import tlvp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && out_ready;
  // Room is taken from a register only, so the input side sees no path from out_ready.
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

[design/tlv_message_parser_top.sv]
// TLV message parser top level: input register, parser core and output buffer.
// An accepted item is registered at the input and again in the output buffer.
// Throughput: one byte per cycle while the output buffer has room; the core
// updates its parse state in one pass. Reset (rst, synchronous, active high)
// clears the parse state and the stages and sets start_word to 0x4040.
// Depends on tlvp_pkg, tlvp_core and tlvp_out_buf.
module tlv_message_parser_top import tlvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,    // start_word [15:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // in_byte [7:0]
  input  logic        s_tlast,     // buffer_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // msg_id [15:0], param_id [31:16], param_length [47:32], data_byte [55:48],
  // data_index [71:56], final_status [74:72], zero [79:75]
  output logic [79:0] m_tdata,
  output logic [2:0]  m_tuser,     // event_res [2:0]
  output logic        m_tlast      // done_res
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       room;
  logic       adv;
  result_t    core_res;
  result_t    out_res;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid && room;
  assign s_tready  = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  tlvp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .step     (adv),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .res      (core_res)
  );

  tlvp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv),
    .push_data (core_res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {5'b00000, out_res.final_status, out_res.data_index, out_res.data_byte,
                    out_res.param_length, out_res.param_id, out_res.msg_id};
  assign m_tuser = out_res.event_res;
  assign m_tlast = out_res.done_res;

endmodule

[test/tb_tlv_message_parser_top.sv]
// Self-checking testbench for tlv_message_parser_top: drives byte streams through
// the slave port and compares every result item against a behavioural parser model.
// Depends on tlvp_pkg and the parser RTL.
module tb_tlv_message_parser_top;
  import tlvp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {WALK_HEADER, WALK_PHDR, WALK_PDATA, WALK_IGNORE} walk_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  tlv_message_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Parser model state.
  walk_t       walk;
  logic [15:0] rx_count;
  logic [15:0] shift_word;
  logic        start_bad;
  logic [15:0] tot_len;
  logic [15:0] msg_id_q;
  logic [15:0] plen_q;
  logic [15:0] pid_q;
  int          pbytes;
  logic [2:0]  err_q;
  logic [15:0] start_word_cfg = START_WORD_RESET;

  result_t     predicted_items[$];
  logic [7:0]  frame_bytes[$];
  int          errors = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          send_idle_pct = 8;
  int          recv_stall_pct = 87;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic void clear_walk();
    walk = WALK_HEADER;
    rx_count = '0;
    shift_word = '0;
    start_bad = 1'b0;
    tot_len = '0;
    msg_id_q = '0;
    plen_q = '0;
    pid_q = '0;
    pbytes = 0;
    err_q = ST_OPEN;
  endfunction

  // Start another parameter only if a whole parameter header still fits.
  function automatic void pick_next_field(input int used);
    pbytes = 0;
    if (int'(tot_len) > used && int'(tot_len) - used >= int'(PHDR_BYTES)) begin
      walk = WALK_PHDR;
    end else begin
      walk = WALK_IGNORE;
    end
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b, input logic last);
    result_t r;
    int pos;
    int pstart;
    int left;
    r = '0;
    pos = int'(rx_count);
    r.event_res = EV_IGNORED;
    if (rx_count != 16'hFFFF) rx_count++;
    case (walk)
      WALK_HEADER: begin
        shift_word = {shift_word[7:0], b};
        r.event_res = EV_NONE;
        if (pos == 1) begin
          start_bad = (shift_word != start_word_cfg);
        end else if (pos == 3) begin
          tot_len = shift_word;
        end else if (pos >= 5) begin
          msg_id_q = shift_word;
          if (start_bad) begin
            err_q = ST_BADSTART;
            walk = WALK_IGNORE;
          end else if (tot_len < HDR_BYTES) begin
            err_q = ST_BADTOTAL;
            walk = WALK_IGNORE;
          end else begin
            r.event_res = EV_HEADER;
            pick_next_field(int'(HDR_BYTES));
          end
        end
      end
      WALK_PHDR: begin
        shift_word = {shift_word[7:0], b};
        pbytes++;
        r.event_res = EV_NONE;
        if (pbytes == 2) begin
          plen_q = shift_word;
        end else if (pbytes >= int'(PHDR_BYTES)) begin
          pstart = pos - 3;
          left = (int'(tot_len) > pstart) ? int'(tot_len) - pstart : 0;
          pid_q = shift_word;
          if (plen_q < PHDR_BYTES || int'(plen_q) > left) begin
            err_q = ST_BADPARAM;
            walk = WALK_IGNORE;
          end else begin
            r.event_res = EV_PHDR;
            if (plen_q == PHDR_BYTES) pick_next_field(pos + 1);
            else walk = WALK_PDATA;
          end
        end
      end
      WALK_PDATA: begin
        r.event_res = EV_DATA;
        r.data_byte = b;
        r.data_index = 16'(pbytes - int'(PHDR_BYTES));
        pbytes++;
        if (pbytes >= int'(plen_q)) pick_next_field(pos + 1);
      end
      default: ;
    endcase
    r.msg_id = msg_id_q;
    r.param_id = pid_q;
    r.param_length = plen_q;
    r.done_res = last;
    if (last) begin
      if (rx_count < HDR_BYTES) r.final_status = ST_SHORT;
      else if (err_q == ST_BADSTART || err_q == ST_BADTOTAL) r.final_status = err_q;
      else if (tot_len > rx_count) r.final_status = ST_BADTOTAL;
      else if (err_q == ST_BADPARAM) r.final_status = ST_BADPARAM;
      else r.final_status = ST_OK;
      clear_walk();
    end
    return r;
  endfunction

  // Cycle budget.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_items.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        errors++;
      end else begin
        want = predicted_items.pop_front();
        check_field("event_res", want.event_res, m_tuser);
        check_field("msg_id", want.msg_id, m_tdata[15:0]);
        check_field("param_id", want.param_id, m_tdata[31:16]);
        check_field("param_length", want.param_length, m_tdata[47:32]);
        check_field("data_byte", want.data_byte, m_tdata[55:48]);
        check_field("data_index", want.data_index, m_tdata[71:56]);
        check_field("final_status", want.final_status, m_tdata[74:72]);
        check_field("pad", 0, m_tdata[79:75]);
        check_field("done_res", want.done_res, m_tlast);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predicted_items.push_back(parse_byte(b, last));
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Stop offering items and wait for every outstanding result.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (predicted_items.size() != 0);
  endtask

  task automatic write_start_word(input logic [15:0] word);
    cfg_valid <= 1'b1;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_word_cfg = word;
  endtask

  // Mostly well-formed messages with random content; the rest are damaged on purpose.
  task automatic make_frame();
    int mode;
    int n_params;
    int plen;
    int total;
    int cut;
    logic [15:0] w;
    frame_bytes.delete();
    mode = $urandom_range(99);
    n_params = $urandom_range(3, (mode >= 76 && mode < 84) ? 1 : 0);
    frame_bytes = '{start_word_cfg[15:8], start_word_cfg[7:0], 8'h00, 8'h00,
                    8'($urandom), 8'($urandom)};
    repeat (n_params) begin
      plen = ($urandom_range(3) == 0) ? 4 : $urandom_range(5, 12);
      frame_bytes.push_back(8'(plen >> 8));
      frame_bytes.push_back(8'(plen));
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'($urandom));
      repeat (plen - 4) frame_bytes.push_back(8'($urandom));
    end
    // A short tail inside the total length ends the parameter walk early.
    repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
    total = frame_bytes.size();
    frame_bytes[2] = 8'(total >> 8);
    frame_bytes[3] = 8'(total);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
    end
    if (mode < 70) begin
      // well-formed
    end else if (mode < 76) begin
      frame_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    end else if (mode < 84) begin
      if ($urandom_range(1) == 0) w = 16'($urandom_range(0, 3));
      else w = 16'($urandom_range(total - 5, 65535));
      frame_bytes[6] = w[15:8];
      frame_bytes[7] = w[7:0];
    end else if (mode < 90) begin
      frame_bytes[2] = 8'h00;
      frame_bytes[3] = 8'($urandom_range(0, 5));
    end else if (mode < 96) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  // Empty-data parameter is left to the random part; this one has a data byte,
  // a three-byte tail inside the total and one byte past it.
  task automatic test_good_frame();
    frame_bytes = '{8'h40, 8'h40, 8'h00, 8'h0E, 8'hFF, 8'hFF,
                    8'h00, 8'h05, 8'hFF, 8'hFF, 8'h80,
                    8'h01, 8'h02, 8'h03, 8'h00};
    send_frame();
  endtask

  task automatic test_short_buffer();
    frame_bytes = '{8'hFF};
    send_frame();
  endtask

  task automatic test_header_errors();
    wait_drained();
    write_start_word(16'hFFFF);
    frame_bytes = '{8'h40, 8'h40, 8'h00, 8'h06, 8'h00, 8'h00};
    send_frame();
    frame_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h05, 8'h12, 8'h34};
    send_frame();
  endtask

  task automatic test_length_errors();
    // Parameter length below its own header.
    frame_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h0A, 8'h00, 8'h00,
                    8'h00, 8'h03, 8'hAB, 8'hCD};
    send_frame();
    // Total length larger than what the buffer delivers.
    frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01};
    send_frame();
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct,
                                    input logic [15:0] word, input bit squeeze);
    int target;
    wait_drained();
    write_start_word(word);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    if (squeeze) hold_req <= hold_req + 1;
    target = items_sent + 180;
    while (items_sent < target) begin
      make_frame();
      send_frame();
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  initial begin
    clear_walk();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_good_frame();
    test_short_buffer();
    test_header_errors();
    test_length_errors();
    test_random_frames(8, 87, 16'h0000, 1'b0);
    test_random_frames(87, 8, 16'($urandom_range(1, 16'hFFFE)), 1'b0);
    test_random_frames(0, 0, 16'hFFFF, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);
    if (predicted_items.size() != 0) begin
      $error("%0d result items never arrived", predicted_items.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tlvp_pkg.sv
design/tlvp_core.sv
design/tlvp_out_buf.sv
design/tlv_message_parser_top.sv
test/tb_tlv_message_parser_top.sv
